// ===== rtl/ptf_pkg.sv =====
package ptf_pkg;

  localparam logic [1:0] OP_START_ABS = 2'd0;
  localparam logic [1:0] OP_START_REL = 2'd1;
  localparam logic [1:0] OP_FORWARD   = 2'd2;

  localparam int unsigned FIELD_BITS = 63;
  localparam int unsigned COUNT_BITS = 32;

  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_t;

endpackage

// ===== rtl/ptf_alu.sv =====
module ptf_alu
  import ptf_pkg::*;
#(
  parameter int unsigned WIDTH = 64
) (
  input  logic [WIDTH-1:0] a,
  input  logic [WIDTH-1:0] b,
  input  alu_op_t          op,
  output logic [WIDTH:0]   res
);

  // top bit is carry for add, borrow for subtract
  always_comb begin
    unique case (op)
      ALU_ADD: res = {1'b0, a} + {1'b0, b};
      ALU_SUB: res = {1'b0, a} - {1'b0, b};
      default: res = '0;
    endcase
  end

endmodule

// ===== rtl/periodic_timer_forward_unit.sv =====
// Channel  | Handshake         | Payload
// ---------+-------------------+-------------------------------------------
// command  | start, busy       | operation, now_ns, value_ns
// result   | done (one cycle)  | overrun_count, expiry_ns, error_flag
//
// A transaction is taken when start is high and busy is low; busy is high until
// its result. An absolute start, an unused code or a zero-interval forward
// registers its result on the accepting edge and stays idle; a relative start
// passes through S_ADDV, an unexpired forward through S_DIFF, and an expired
// forward through S_DIFF, S_DIV, S_BASE and S_ADDV, the restoring divide
// running one quotient bit a cycle through the shared adder/subtractor. rst
// (synchronous) clears the expiry to zero and goes idle.
// The receiver cannot stall; done marks each result for exactly one cycle.
module periodic_timer_forward_unit
  import ptf_pkg::*;
#(
  parameter int unsigned TIME_BITS = 63
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic [1:0]            operation,
  input  logic [FIELD_BITS-1:0] now_ns,
  input  logic [FIELD_BITS-1:0] value_ns,
  output logic                  done,
  output logic [COUNT_BITS-1:0] overrun_count,
  output logic [FIELD_BITS-1:0] expiry_ns,
  output logic                  error_flag
);

  localparam int unsigned W     = TIME_BITS;
  localparam int unsigned CNT_W = $clog2(TIME_BITS);
  localparam logic [63:0] TMAX64 = {64{1'b1}} >> (64 - TIME_BITS);
  localparam logic [W-1:0] TIME_MAX = TMAX64[W-1:0];

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIFF,
    S_DIV,
    S_BASE,
    S_ADDV
  } state_t;

  state_t           state;
  logic [W-1:0]     expiry;
  logic [W-1:0]     now_r;
  logic [W-1:0]     val_r;
  logic [W-1:0]     quo;
  logic [W-1:0]     rem;
  logic [W-1:0]     sum_a;
  logic [CNT_W-1:0] cnt;

  logic [63:0]  now64;
  logic [63:0]  val64;
  logic [63:0]  exp64;
  logic [W-1:0] now_clamp;
  logic [W-1:0] val_clamp;

  logic [W:0]   alu_a;
  logic [W:0]   alu_b;
  alu_op_t      alu_op;
  logic [W+1:0] alu_res;
  logic         alu_borrow;
  logic [COUNT_BITS-1:0] overrun_next;

  assign now64     = 64'(now_ns);
  assign val64     = 64'(value_ns);
  assign now_clamp = (now64 > TMAX64) ? TIME_MAX : now64[W-1:0];
  assign val_clamp = (val64 > TMAX64) ? TIME_MAX : val64[W-1:0];

  assign exp64     = 64'(expiry);
  assign busy      = (state != S_IDLE);

  always_comb begin
    alu_a  = {1'b0, now_r};
    alu_b  = {1'b0, expiry};
    alu_op = ALU_SUB;
    unique case (state)
      S_IDLE: begin
        alu_a = '0;
        alu_b = '0;
      end
      S_DIFF: begin
        alu_a = {1'b0, now_r};
        alu_b = {1'b0, expiry};
      end
      S_DIV: begin
        alu_a = {rem, quo[W-1]};
        alu_b = {1'b0, val_r};
      end
      S_BASE: begin
        alu_a = {1'b0, now_r};
        alu_b = {1'b0, rem};
      end
      S_ADDV: begin
        alu_a  = {1'b0, sum_a};
        alu_b  = {1'b0, val_r};
        alu_op = ALU_ADD;
      end
      default: begin
        alu_a = '0;
        alu_b = '0;
      end
    endcase
  end

  ptf_alu #(
    .WIDTH(W + 1)
  ) u_alu (
    .a  (alu_a),
    .b  (alu_b),
    .op (alu_op),
    .res(alu_res)
  );

  assign alu_borrow = alu_res[W+1];

  // overrun = quotient + 1, saturated
  assign overrun_next = (65'(quo) >= 65'h0_FFFF_FFFF) ? {COUNT_BITS{1'b1}}
                                                      : quo[COUNT_BITS-1:0] + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      done   <= 1'b0;
      expiry <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            now_r         <= now_clamp;
            val_r         <= val_clamp;
            overrun_count <= '0;
            error_flag    <= (operation == OP_FORWARD) && (val_clamp == '0);
            priority if (operation == OP_START_ABS) begin
              expiry    <= val_clamp;
              expiry_ns <= FIELD_BITS'(64'(val_clamp));
              done      <= 1'b1;
            end else if (operation == OP_START_REL) begin
              sum_a <= now_clamp;
              done  <= 1'b0;
              state <= S_ADDV;
            end else if (operation == OP_FORWARD) begin
              if (val_clamp == '0) begin
                expiry_ns  <= exp64[FIELD_BITS-1:0];
                done       <= 1'b1;
              end else begin
                done  <= 1'b0;
                state <= S_DIFF;
              end
            end else begin
              expiry_ns <= exp64[FIELD_BITS-1:0];
              done      <= 1'b1;
            end
          end else begin
            done <= 1'b0;
          end
        end
        S_DIFF: begin
          if (alu_borrow) begin
            expiry_ns <= exp64[FIELD_BITS-1:0];
            done      <= 1'b1;
            state     <= S_IDLE;
          end else begin
            quo   <= alu_res[W-1:0];
            rem   <= '0;
            cnt   <= CNT_W'(TIME_BITS - 1);
            done  <= 1'b0;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          quo  <= {quo[W-2:0], ~alu_borrow};
          rem  <= alu_borrow ? {rem[W-2:0], quo[W-1]} : alu_res[W-1:0];
          cnt  <= cnt - 1'b1;
          done <= 1'b0;
          if (cnt == '0) begin
            state <= S_BASE;
          end
        end
        S_BASE: begin
          // now - remainder, then one interval on top
          sum_a         <= alu_res[W-1:0];
          overrun_count <= overrun_next;
          done          <= 1'b0;
          state         <= S_ADDV;
        end
        S_ADDV: begin
          if (alu_res[W]) begin
            expiry    <= TIME_MAX;
            expiry_ns <= TMAX64[FIELD_BITS-1:0];
          end else begin
            expiry    <= alu_res[W-1:0];
            expiry_ns <= FIELD_BITS'(64'(alu_res[W-1:0]));
          end
          done  <= 1'b1;
          state <= S_IDLE;
        end
        default: begin
          done  <= 1'b0;
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
